// ----- hw/rtl/swsfr_pkg.sv -----
// Shared constants, command and status types for the sliding-window sender.
package swsfr_pkg;

	localparam int MAX_WINDOW    = 16;
	localparam int SLOT_BITS     = $clog2(MAX_WINDOW);
	localparam int SEQ_BITS      = 16;
	localparam int PAYLOAD_BITS  = 32;
	localparam int WSIZE_BITS    = 5;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 16;
	localparam int DUP_BITS      = 2;
	localparam int DUP_LIMIT     = 2;
	localparam int SLIDE_BITS    = $clog2(MAX_WINDOW + 1);

	localparam logic [WSIZE_BITS-1:0] WSIZE_RESET  = WSIZE_BITS'(4);
	localparam logic [SEQ_BITS-1:0]   SLIMIT_RESET = {SEQ_BITS{1'b1}};

	localparam logic [1:0] ACT_SEND    = 2'd0;
	localparam logic [1:0] ACT_ACK     = 2'd1;
	localparam logic [1:0] ACT_TIMEOUT = 2'd2;

	localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_SIZE = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] REG_SEQ_LIMIT   = CFG_IDX_BITS'(1);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic do_send;
		logic ack_mark;
		logic dup_bump;
		logic rd_base;
		logic resend_base;
		logic resend_tseq;
		logic slide_step;
		logic load_rd;
		logic publish;
	} swsfr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] action;
		logic       ck;
		logic       waiting;
		logic       ack_new;
		logic       dup_hit;
		logic       outstanding;
		logic       tseq_in;
		logic       slide_ok;
	} swsfr_sts_t;

endpackage

// ----- hw/rtl/swsfr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module swsfr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hw/rtl/swsfr_ctrl.sv -----
// Controller state machine that sequences one transaction through the datapath.
module swsfr_ctrl import swsfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  swsfr_sts_t sts,
	output swsfr_cmd_t cmd,
	output logic       busy
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_EXEC   = 3'd1;
	localparam logic [2:0] ST_SLIDE  = 3'd2;
	localparam logic [2:0] ST_READ   = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	logic [2:0]            state_q, state_d;
	logic [SLIDE_BITS-1:0] slide_cnt_q, slide_cnt_d;

	always_comb begin
		cmd         = '0;
		state_d     = state_q;
		slide_cnt_d = slide_cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_FINISH;
				unique case (sts.action)
					ACT_SEND: begin
						cmd.do_send = !sts.waiting;
					end
					ACT_ACK: begin
						if (sts.ck) begin
							if (sts.ack_new) begin
								cmd.ack_mark = 1'b1;
								slide_cnt_d  = '0;
								state_d      = ST_SLIDE;
							end else begin
								cmd.dup_bump = 1'b1;
								// The duplicate count reaching its limit resends the base packet if one is outstanding.
								if (sts.dup_hit && sts.outstanding) begin
									cmd.rd_base     = 1'b1;
									cmd.resend_base = 1'b1;
									state_d         = ST_READ;
								end
							end
						end
					end
					ACT_TIMEOUT: begin
						if (sts.tseq_in) begin
							cmd.resend_tseq = 1'b1;
							state_d         = ST_READ;
						end
					end
					default: begin
						state_d = ST_FINISH;
					end
				endcase
			end
			ST_SLIDE: begin
				if (slide_cnt_q < SLIDE_BITS'(MAX_WINDOW) && sts.slide_ok) begin
					cmd.slide_step = 1'b1;
					slide_cnt_d    = slide_cnt_q + 1'b1;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_READ: begin
				cmd.load_rd = 1'b1;
				state_d     = ST_FINISH;
			end
			ST_FINISH: begin
				cmd.publish = 1'b1;
				state_d     = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slide_cnt_q <= '0;
		end else begin
			state_q     <= state_d;
			slide_cnt_q <= slide_cnt_d;
		end
	end

endmodule

// ----- hw/rtl/swsfr_dp.sv -----
// Datapath: window registers, acked marks, payload store and result registers.
module swsfr_dp import swsfr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  swsfr_cmd_t               cmd,
	output swsfr_sts_t               sts,
	input  logic [1:0]               action,
	input  logic [PAYLOAD_BITS-1:0]  payload,
	input  logic                     checksum_ok,
	input  logic [SEQ_BITS-1:0]      ack_num,
	input  logic [SEQ_BITS-1:0]      timeout_seq,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_idx,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	output logic                     done,
	output logic                     accepted,
	output logic                     tx_valid,
	output logic [SEQ_BITS-1:0]      tx_seq,
	output logic [PAYLOAD_BITS-1:0]  tx_payload,
	output logic                     stop_valid,
	output logic [SEQ_BITS-1:0]      stop_seq,
	output logic                     window_full,
	output logic [SEQ_BITS-1:0]      window_base
);

	// Captured transaction.
	logic [1:0]              action_q;
	logic [PAYLOAD_BITS-1:0] payload_q;
	logic                    ck_q;
	logic [SEQ_BITS-1:0]     ack_q;
	logic [SEQ_BITS-1:0]     tseq_q;

	// Sender state and configuration.
	logic [SEQ_BITS-1:0]   next_q;
	logic [SEQ_BITS-1:0]   base_q;
	logic [DUP_BITS-1:0]   dup_q;
	logic [MAX_WINDOW-1:0] marks_q;
	logic [WSIZE_BITS-1:0] wsize_q;
	logic [SEQ_BITS-1:0]   slimit_q;

	// Result being built up for the current transaction.
	logic                    acc_accepted_q;
	logic                    acc_txv_q;
	logic [SEQ_BITS-1:0]     acc_txs_q;
	logic [PAYLOAD_BITS-1:0] acc_txp_q;
	logic                    acc_stv_q;
	logic [SEQ_BITS-1:0]     acc_sts_q;

	logic [WSIZE_BITS-1:0]   wsize_eff;
	logic [SEQ_BITS:0]       end_sum;
	logic [SEQ_BITS-1:0]     window_end;
	logic                    waiting;
	logic [SLOT_BITS-1:0]    slot_next, slot_base, slot_ack, slot_tseq, ram_raddr;
	logic [PAYLOAD_BITS-1:0] ram_rdata;
	logic [DUP_BITS:0]       dup_inc;

	// The window end always follows from the base and the registers, so it is
	// recomputed continuously instead of being stored.
	assign wsize_eff  = (wsize_q > WSIZE_BITS'(MAX_WINDOW)) ? WSIZE_BITS'(MAX_WINDOW) : wsize_q;
	assign end_sum    = (SEQ_BITS+1)'(base_q) + (SEQ_BITS+1)'(wsize_eff);
	assign window_end = (end_sum > (SEQ_BITS+1)'(slimit_q)) ? slimit_q : end_sum[SEQ_BITS-1:0];
	assign waiting    = (next_q >= window_end);

	assign slot_next = next_q[SLOT_BITS-1:0];
	assign slot_base = base_q[SLOT_BITS-1:0];
	assign slot_ack  = ack_q[SLOT_BITS-1:0];
	assign slot_tseq = tseq_q[SLOT_BITS-1:0];
	assign ram_raddr = cmd.rd_base ? slot_base : slot_tseq;
	assign dup_inc   = (DUP_BITS+1)'(dup_q) + 1'b1;

	assign sts.action      = action_q;
	assign sts.ck          = ck_q;
	assign sts.waiting     = waiting;
	assign sts.ack_new     = (ack_q >= base_q) && (ack_q < next_q) && !marks_q[slot_ack];
	assign sts.dup_hit     = (dup_inc >= (DUP_BITS+1)'(DUP_LIMIT));
	assign sts.outstanding = (base_q < next_q);
	assign sts.tseq_in     = (tseq_q >= base_q) && (tseq_q < next_q);
	assign sts.slide_ok    = (base_q < next_q) && marks_q[slot_base];

	swsfr_ram #(
		.WIDTH(PAYLOAD_BITS),
		.DEPTH(MAX_WINDOW)
	) u_payload_ram (
		.clk  (clk),
		.we   (cmd.do_send),
		.waddr(slot_next),
		.wdata(payload_q),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_q   <= '0;
			base_q   <= '0;
			dup_q    <= '0;
			marks_q  <= '0;
			wsize_q  <= WSIZE_RESET;
			slimit_q <= SLIMIT_RESET;
			done     <= 1'b0;
		end else begin
			done <= cmd.publish;
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_WINDOW_SIZE: wsize_q  <= cfg_data[WSIZE_BITS-1:0];
					REG_SEQ_LIMIT:   slimit_q <= cfg_data[SEQ_BITS-1:0];
					default: begin
					end
				endcase
			end
			if (cmd.do_send) begin
				marks_q[slot_next] <= 1'b0;
				next_q             <= next_q + 1'b1;
			end
			if (cmd.ack_mark) begin
				marks_q[slot_ack] <= 1'b1;
				dup_q             <= '0;
			end
			if (cmd.dup_bump) begin
				dup_q <= sts.dup_hit ? '0 : dup_inc[DUP_BITS-1:0];
			end
			if (cmd.slide_step) begin
				marks_q[slot_base] <= 1'b0;
				base_q             <= base_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q       <= action;
			payload_q      <= payload;
			ck_q           <= checksum_ok;
			ack_q          <= ack_num;
			tseq_q         <= timeout_seq;
			acc_accepted_q <= 1'b0;
			acc_txv_q      <= 1'b0;
			acc_txs_q      <= '0;
			acc_txp_q      <= '0;
			acc_stv_q      <= 1'b0;
			acc_sts_q      <= '0;
		end
		if (cmd.do_send) begin
			acc_accepted_q <= 1'b1;
			acc_txv_q      <= 1'b1;
			acc_txs_q      <= next_q;
			acc_txp_q      <= payload_q;
		end
		if (cmd.ack_mark) begin
			acc_stv_q <= 1'b1;
			acc_sts_q <= ack_q;
		end
		if (cmd.resend_base) begin
			acc_txv_q <= 1'b1;
			acc_txs_q <= base_q;
		end
		if (cmd.resend_tseq) begin
			acc_txv_q <= 1'b1;
			acc_txs_q <= tseq_q;
		end
		if (cmd.load_rd) begin
			acc_txp_q <= ram_rdata;
		end
		if (cmd.publish) begin
			accepted    <= acc_accepted_q;
			tx_valid    <= acc_txv_q;
			tx_seq      <= acc_txs_q;
			tx_payload  <= acc_txp_q;
			stop_valid  <= acc_stv_q;
			stop_seq    <= acc_sts_q;
			window_full <= waiting;
			window_base <= base_q;
		end
	end

endmodule

// ----- hw/rtl/sliding_window_sender_fast_retx_top.sv -----
// Top level of the sliding-window sender with fast retransmit.
// A send, a timeout or an ignored ack goes from capture through execution to the result
// registers and done; a resend adds a payload memory read, and a new ack adds a slide of
// the base over k packets (k at most 16, one packet per cycle). Busy stays high until the
// cycle of done, so no new item is taken before then. Reset clears the window and the acked
// marks and reloads the config registers; the payload store and result registers are not cleared.
module sliding_window_sender_fast_retx_top import swsfr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               action,
	input  logic [PAYLOAD_BITS-1:0]  payload,
	input  logic                     checksum_ok,
	input  logic [SEQ_BITS-1:0]      ack_num,
	input  logic [SEQ_BITS-1:0]      timeout_seq,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_idx,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	output logic                     done,
	output logic                     accepted,
	output logic                     tx_valid,
	output logic [SEQ_BITS-1:0]      tx_seq,
	output logic [PAYLOAD_BITS-1:0]  tx_payload,
	output logic                     stop_valid,
	output logic [SEQ_BITS-1:0]      stop_seq,
	output logic                     window_full,
	output logic [SEQ_BITS-1:0]      window_base
);

	swsfr_cmd_t cmd;
	swsfr_sts_t sts;

	swsfr_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy)
	);

	swsfr_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.action     (action),
		.payload    (payload),
		.checksum_ok(checksum_ok),
		.ack_num    (ack_num),
		.timeout_seq(timeout_seq),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.done       (done),
		.accepted   (accepted),
		.tx_valid   (tx_valid),
		.tx_seq     (tx_seq),
		.tx_payload (tx_payload),
		.stop_valid (stop_valid),
		.stop_seq   (stop_seq),
		.window_full(window_full),
		.window_base(window_base)
	);

endmodule

// ----- hw/rtl/swsfr_checker.sv -----
// Port-level checker for the sliding-window sender, bound to the top level.
module swsfr_checker import swsfr_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    start,
	input logic                    busy,
	input logic                    done,
	input logic                    accepted,
	input logic                    tx_valid,
	input logic [SEQ_BITS-1:0]     tx_seq,
	input logic [PAYLOAD_BITS-1:0] tx_payload,
	input logic                    stop_valid
);

	// An accepted transaction keeps the block busy in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	// Each result strobe is a single cycle and falls in an idle cycle.
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy ##1 !done)
		else $error("result strobe overlaps work or repeats");

	// A taken send always transmits and never stops a timer.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && accepted) |-> (tx_valid && !stop_valid))
		else $error("accepted send without transmission");

	// Without a transmission the packet fields read as zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && !tx_valid) |-> (tx_seq == '0 && tx_payload == '0))
		else $error("packet fields not cleared without transmission");

endmodule

bind sliding_window_sender_fast_retx_top swsfr_checker u_swsfr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.accepted  (accepted),
	.tx_valid  (tx_valid),
	.tx_seq    (tx_seq),
	.tx_payload(tx_payload),
	.stop_valid(stop_valid)
);

// ----- test/sliding_window_sender_fast_retx_top_tb.sv -----
// Self-checking testbench for the sliding-window sender with fast retransmit.
module sliding_window_sender_fast_retx_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import swsfr_pkg::*;

	// Action code that the block takes without any effect.
	localparam logic [1:0] ACT_IDLE = 2'd3;
	// Register indexes that hold no register.
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_A = CFG_IDX_BITS'(2);
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_B = CFG_IDX_BITS'(3);
	localparam int CYCLE_LIMIT  = 100000;
	localparam int DRAIN_CYCLES = 24;

	typedef struct {
		logic                    accepted;
		logic                    tx_valid;
		logic [SEQ_BITS-1:0]     tx_seq;
		logic [PAYLOAD_BITS-1:0] tx_payload;
		logic                    stop_valid;
		logic [SEQ_BITS-1:0]     stop_seq;
		logic                    window_full;
		logic [SEQ_BITS-1:0]     window_base;
	} tx_outcome_t;

	// Mirrors the window state and queues the outcome of every accepted transaction.
	class window_tracker;
		logic [WSIZE_BITS-1:0]   wsize;
		logic [SEQ_BITS-1:0]     slimit;
		logic [SEQ_BITS-1:0]     next_seq;
		logic [SEQ_BITS-1:0]     base_seq;
		logic [SEQ_BITS-1:0]     wend;
		logic                    full;
		int                      dups;
		logic                    acked [MAX_WINDOW];
		logic [PAYLOAD_BITS-1:0] handles [MAX_WINDOW];
		tx_outcome_t             due_outcomes [$];
		int                      errors;

		function new();
			wsize = WSIZE_RESET;
			slimit = SLIMIT_RESET;
			next_seq = '0;
			base_seq = '0;
			dups = 0;
			errors = 0;
			foreach (acked[i]) acked[i] = 1'b0;
			foreach (handles[i]) handles[i] = '0;
			reopen();
		endfunction

		function void reopen();
			logic [SEQ_BITS:0] lim_end;
			int unsigned w;
			w = (wsize > MAX_WINDOW) ? MAX_WINDOW : wsize;
			lim_end = {1'b0, base_seq} + (SEQ_BITS+1)'(w);
			if (lim_end > {1'b0, slimit}) lim_end = {1'b0, slimit};
			wend = lim_end[SEQ_BITS-1:0];
			full = next_seq >= wend;
		endfunction

		function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
			if (idx == REG_WINDOW_SIZE) wsize = data[WSIZE_BITS-1:0];
			else if (idx == REG_SEQ_LIMIT) slimit = data[SEQ_BITS-1:0];
			else return;
			reopen();
		endfunction

		function void log_request(logic [1:0] act, logic [PAYLOAD_BITS-1:0] pay, logic ck,
				logic [SEQ_BITS-1:0] ack, logic [SEQ_BITS-1:0] tseq);
			tx_outcome_t o;
			int unsigned steps;
			o = '{default: '0};
			case (act)
			ACT_SEND: if (!full) begin
				handles[next_seq % MAX_WINDOW] = pay;
				acked[next_seq % MAX_WINDOW] = 1'b0;
				o.accepted = 1'b1;
				o.tx_valid = 1'b1;
				o.tx_seq = next_seq;
				o.tx_payload = pay;
				next_seq++;
				full = next_seq >= wend;
			end
			ACT_ACK: if (ck) begin
				if (ack >= base_seq && ack < next_seq && !acked[ack % MAX_WINDOW]) begin
					dups = 0;
					o.stop_valid = 1'b1;
					o.stop_seq = ack;
					acked[ack % MAX_WINDOW] = 1'b1;
					steps = 0;
					while (steps < MAX_WINDOW && base_seq < next_seq &&
							acked[base_seq % MAX_WINDOW]) begin
						acked[base_seq % MAX_WINDOW] = 1'b0;
						base_seq++;
						steps++;
					end
					reopen();
				end else begin
					dups++;
				end
				// Fast retransmit of the oldest outstanding packet.
				if (dups >= DUP_LIMIT) begin
					if (base_seq < next_seq) begin
						o.tx_valid = 1'b1;
						o.tx_seq = base_seq;
						o.tx_payload = handles[base_seq % MAX_WINDOW];
					end
					dups = 0;
				end
			end
			ACT_TIMEOUT: if (tseq >= base_seq && tseq < next_seq) begin
				o.tx_valid = 1'b1;
				o.tx_seq = tseq;
				o.tx_payload = handles[tseq % MAX_WINDOW];
			end
			default: ;
			endcase
			o.window_full = full;
			o.window_base = base_seq;
			due_outcomes.insert(due_outcomes.size(), o);
		endfunction

		function void compare(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_outcome(tx_outcome_t got);
			tx_outcome_t want;
			if (due_outcomes.size() == 0) begin
				$error("result with no transaction waiting for it");
				errors++;
				return;
			end
			want = due_outcomes[0];
			due_outcomes.delete(0);
			compare("accepted", want.accepted, got.accepted);
			compare("tx_valid", want.tx_valid, got.tx_valid);
			compare("tx_seq", want.tx_seq, got.tx_seq);
			compare("tx_payload", want.tx_payload, got.tx_payload);
			compare("stop_valid", want.stop_valid, got.stop_valid);
			compare("stop_seq", want.stop_seq, got.stop_seq);
			compare("window_full", want.window_full, got.window_full);
			compare("window_base", want.window_base, got.window_base);
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [1:0]               action;
	logic [PAYLOAD_BITS-1:0]  payload;
	logic                     checksum_ok;
	logic [SEQ_BITS-1:0]      ack_num;
	logic [SEQ_BITS-1:0]      timeout_seq;
	logic                     cfg_we;
	logic [CFG_IDX_BITS-1:0]  cfg_idx;
	logic [CFG_DATA_BITS-1:0] cfg_data;
	logic                     done;
	logic                     accepted;
	logic                     tx_valid;
	logic [SEQ_BITS-1:0]      tx_seq;
	logic [PAYLOAD_BITS-1:0]  tx_payload;
	logic                     stop_valid;
	logic [SEQ_BITS-1:0]      stop_seq;
	logic                     window_full;
	logic [SEQ_BITS-1:0]      window_base;

	window_tracker tracker;
	int            cycles;

	sliding_window_sender_fast_retx_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.action      (action),
		.payload     (payload),
		.checksum_ok (checksum_ok),
		.ack_num     (ack_num),
		.timeout_seq (timeout_seq),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_data    (cfg_data),
		.done        (done),
		.accepted    (accepted),
		.tx_valid    (tx_valid),
		.tx_seq      (tx_seq),
		.tx_payload  (tx_payload),
		.stop_valid  (stop_valid),
		.stop_seq    (stop_seq),
		.window_full (window_full),
		.window_base (window_base)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			tracker.check_outcome(tx_outcome_t'{accepted, tx_valid, tx_seq, tx_payload,
				stop_valid, stop_seq, window_full, window_base});
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("sliding_window_sender_fast_retx_top_tb NOT OK");
			$finish;
		end
	end

	task automatic issue(input logic [1:0] act, input logic [PAYLOAD_BITS-1:0] pay,
			input logic ck, input logic [SEQ_BITS-1:0] ack, input logic [SEQ_BITS-1:0] tseq);
		@(negedge clk);
		start <= 1'b1;
		action <= act;
		payload <= pay;
		checksum_ok <= ck;
		ack_num <= ack;
		timeout_seq <= tseq;
		do @(posedge clk); while (busy);
		tracker.log_request(act, pay, ck, ack, tseq);
	endtask

	task automatic idle(input int n);
		@(negedge clk);
		start <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// Holds off new transactions until every outcome has come back and the block is quiet.
	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (tracker.due_outcomes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		tracker.write_reg(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic reconfigure(input logic [WSIZE_BITS-1:0] wsz, input logic [SEQ_BITS-1:0] lim);
		settle();
		write_reg(REG_WINDOW_SIZE, CFG_DATA_BITS'(wsz));
		write_reg(REG_SEQ_LIMIT, lim);
	endtask

	// Sends, acks and timeouts, the acks and timeouts mostly landing on outstanding packets, with repeats and noise.
	task automatic random_item(input bit gaps);
		int unsigned pick;
		int unsigned span;
		logic [1:0] act;
		logic [PAYLOAD_BITS-1:0] pay;
		logic ck;
		logic [SEQ_BITS-1:0] ack;
		logic [SEQ_BITS-1:0] tseq;
		span = tracker.next_seq - tracker.base_seq;
		pay = $urandom;
		ck = $urandom_range(0, 9) != 0;
		ack = SEQ_BITS'($urandom);
		tseq = SEQ_BITS'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			act = ACT_SEND;
		end else if (pick < 80) begin
			act = ACT_ACK;
			pick = $urandom_range(0, 99);
			if (span != 0 && pick < 60) ack = tracker.base_seq + SEQ_BITS'($urandom_range(0, span - 1));
			else if (pick < 80) ack = tracker.base_seq - 1'b1;
		end else if (pick < 95) begin
			act = ACT_TIMEOUT;
			if (span != 0 && $urandom_range(0, 9) < 7)
				tseq = tracker.base_seq + SEQ_BITS'($urandom_range(0, span - 1));
		end else begin
			act = ACT_IDLE;
		end
		if (gaps && $urandom_range(0, 3) == 0) idle($urandom_range(1, 4));
		issue(act, pay, ck, ack, tseq);
	endtask

	initial begin
		tracker = new();
		cycles = 0;
		arst_n = 1'b0;
		start = 1'b0;
		action = ACT_SEND;
		payload = '0;
		checksum_ok = 1'b0;
		ack_num = '0;
		timeout_seq = '0;
		cfg_we = 1'b0;
		cfg_idx = REG_WINDOW_SIZE;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Nothing outstanding yet: the timeout is ignored and the retransmit sends nothing.
		issue(ACT_TIMEOUT, 32'h0, 1'b0, 16'h0, 16'h0000);
		issue(ACT_ACK, 32'h0, 1'b1, 16'h0000, 16'h0);
		issue(ACT_ACK, 32'h0, 1'b1, 16'hFFFF, 16'h0);
		// Fill the reset window of four, then try one more.
		issue(ACT_SEND, 32'h0000_0000, 1'b0, 16'h0, 16'h0);
		issue(ACT_SEND, 32'hFFFF_FFFF, 1'b0, 16'h0, 16'h0);
		issue(ACT_SEND, 32'hA5A5_A5A5, 1'b0, 16'h0, 16'h0);
		issue(ACT_SEND, 32'h5A5A_5A5A, 1'b0, 16'h0, 16'h0);
		issue(ACT_SEND, 32'h1234_5678, 1'b0, 16'h0, 16'h0);
		issue(ACT_ACK, 32'h0, 1'b0, 16'd1, 16'h0);
		issue(ACT_ACK, 32'h0, 1'b1, 16'd1, 16'h0);
		issue(ACT_ACK, 32'h0, 1'b1, 16'd1, 16'h0);
		issue(ACT_ACK, 32'h0, 1'b1, 16'd1, 16'h0);
		// An acked packet still inside the window is resent on timeout.
		issue(ACT_TIMEOUT, 32'h0, 1'b0, 16'h0, 16'd1);
		issue(ACT_TIMEOUT, 32'h0, 1'b0, 16'h0, 16'hFFFF);
		issue(ACT_IDLE, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 16'hFFFF);
		issue(ACT_ACK, 32'h0, 1'b1, 16'd0, 16'h0);
		issue(ACT_TIMEOUT, 32'h0, 1'b0, 16'h0, 16'd3);
		issue(ACT_SEND, 32'h0F0F_0F0F, 1'b0, 16'h0, 16'h0);
		issue(ACT_ACK, 32'h0, 1'b1, 16'd3, 16'h0);
		issue(ACT_ACK, 32'h0, 1'b1, 16'd2, 16'h0);
		issue(ACT_ACK, 32'h0, 1'b1, 16'd4, 16'h0);

		reconfigure(5'd16, 16'hFFFF);
		repeat (120) random_item(1'b1);
		reconfigure(5'd1, 16'hFFFF);
		repeat (80) random_item(1'b1);
		// A window of zero refuses every send.
		reconfigure(5'd0, 16'hFFFF);
		repeat (30) random_item(1'b1);
		// The sequence limit lands twelve past the current base, so sends stop for good.
		reconfigure(5'd31, 16'hFFFF);
		write_reg(REG_SEQ_LIMIT, tracker.base_seq + 16'd12);
		repeat (100) random_item(1'b1);
		reconfigure(5'd8, 16'h0000);
		repeat (20) random_item(1'b1);
		reconfigure(5'd7, 16'hFFFF);
		write_reg(REG_SPARE_A, CFG_DATA_BITS'($urandom));
		write_reg(REG_SPARE_B, CFG_DATA_BITS'($urandom));
		repeat (150) random_item(1'b1);
		repeat (100) random_item(1'b0);

		settle();
		if (tracker.errors == 0)
			$display("sliding_window_sender_fast_retx_top_tb OK");
		else
			$display("sliding_window_sender_fast_retx_top_tb NOT OK");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/swsfr_pkg.sv
hw/rtl/swsfr_ram.sv
hw/rtl/swsfr_ctrl.sv
hw/rtl/swsfr_dp.sv
hw/rtl/sliding_window_sender_fast_retx_top.sv
hw/rtl/swsfr_checker.sv
test/sliding_window_sender_fast_retx_top_tb.sv
